// ----- rtl/hrpd_pkg.sv -----
package hrpd_pkg;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TARGET_HEADING   = 3'd0,
    REG_COMMANDED_SPEED  = 3'd1,
    REG_PROP_GAIN        = 3'd2,
    REG_DERIV_GAIN       = 3'd3,
    REG_SLOW_SPEED_LIMIT = 3'd4,
    REG_ERROR_DEADBAND   = 3'd5
  } hrpd_reg_e;

  // turn direction kept between ticks
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } hrpd_dir_e;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // reset values of the configuration registers
  localparam logic [8:0]  TargetHeadingRst  = 9'd0;
  localparam logic [7:0]  CommandedSpeedRst = 8'd0;
  localparam logic [15:0] PropGainRst       = 16'd1792;
  localparam logic [15:0] DerivGainRst      = 16'd0;
  localparam logic [7:0]  SlowSpeedRst      = 8'd17;
  localparam logic [7:0]  DeadbandRst       = 8'd10;

  localparam logic [8:0]  FullCircle = 9'd360;
  localparam logic [10:0] PulseCenter = 11'd1500;
  localparam logic [6:0]  PercentMax  = 7'd100;

  // percent = floor(drive * 100 / (45 * 256)) = floor(drive * 5 / 576)
  // saturates at 100 once drive >= 11636; below that a reciprocal
  // multiply by ceil(2^24 * 5 / 576) is exact for every drive value
  localparam logic [26:0] DriveSatLimit = 27'd11636;
  localparam logic [17:0] PctRecip      = 18'd145636;
  localparam int unsigned PctShift      = 24;

  typedef struct packed {
    logic [8:0]  target_heading;
    logic [7:0]  commanded_speed;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [7:0]  slow_speed_limit;
    logic [7:0]  error_deadband;
  } hrpd_cfg_t;

  // error stage -> drive stage
  typedef struct packed {
    logic [7:0] mag;
    logic [7:0] diff;
    logic       turn_right;
    logic       bang;
  } hrpd_err_t;

  // drive stage -> output stage
  typedef struct packed {
    logic [26:0] drive;
    logic [7:0]  mag;
    logic        turn_right;
    logic        bang;
  } hrpd_drv_t;

endpackage

// ----- rtl/hrpd_if.sv -----
// heading request channel
interface hrpd_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] measured_heading;
  logic       restart;

  modport source (output valid, output measured_heading, output restart, input ready);
  modport sink (input valid, input measured_heading, input restart, output ready);
endinterface

// rudder result channel
interface hrpd_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] rudder_pulse_us;
  logic        turn_right;
  logic [7:0]  error_magnitude;
  logic [6:0]  rudder_percent;

  modport source (output valid, output rudder_pulse_us, output turn_right,
                  output error_magnitude, output rudder_percent, input ready);
  modport sink (input valid, input rudder_pulse_us, input turn_right,
                input error_magnitude, input rudder_percent, output ready);
endinterface

// ----- rtl/hrpd_cfg_regs.sv -----
module hrpd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hrpd_pkg::AddrW-1:0] paddr,
  input  logic [hrpd_pkg::DataW-1:0] pwdata,
  output logic [hrpd_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output hrpd_pkg::hrpd_cfg_t        cfg_o
);

  hrpd_pkg::hrpd_cfg_t cfg_q, cfg_d;
  logic [2:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        hrpd_pkg::REG_TARGET_HEADING:   cfg_d.target_heading   = pwdata[8:0];
        hrpd_pkg::REG_COMMANDED_SPEED:  cfg_d.commanded_speed  = pwdata[7:0];
        hrpd_pkg::REG_PROP_GAIN:        cfg_d.prop_gain        = pwdata[15:0];
        hrpd_pkg::REG_DERIV_GAIN:       cfg_d.deriv_gain       = pwdata[15:0];
        hrpd_pkg::REG_SLOW_SPEED_LIMIT: cfg_d.slow_speed_limit = pwdata[7:0];
        hrpd_pkg::REG_ERROR_DEADBAND:   cfg_d.error_deadband   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_heading   <= hrpd_pkg::TargetHeadingRst;
      cfg_q.commanded_speed  <= hrpd_pkg::CommandedSpeedRst;
      cfg_q.prop_gain        <= hrpd_pkg::PropGainRst;
      cfg_q.deriv_gain       <= hrpd_pkg::DerivGainRst;
      cfg_q.slow_speed_limit <= hrpd_pkg::SlowSpeedRst;
      cfg_q.error_deadband   <= hrpd_pkg::DeadbandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hrpd_pkg::REG_TARGET_HEADING:   prdata = {23'd0, cfg_q.target_heading};
      hrpd_pkg::REG_COMMANDED_SPEED:  prdata = {24'd0, cfg_q.commanded_speed};
      hrpd_pkg::REG_PROP_GAIN:        prdata = {16'd0, cfg_q.prop_gain};
      hrpd_pkg::REG_DERIV_GAIN:       prdata = {16'd0, cfg_q.deriv_gain};
      hrpd_pkg::REG_SLOW_SPEED_LIMIT: prdata = {24'd0, cfg_q.slow_speed_limit};
      hrpd_pkg::REG_ERROR_DEADBAND:   prdata = {24'd0, cfg_q.error_deadband};
      default:                        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/hrpd_error_stage.sv -----
module hrpd_error_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [8:0]          measured_heading_i,
  input  logic                restart_i,
  input  hrpd_pkg::hrpd_cfg_t cfg_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hrpd_pkg::hrpd_err_t err_o
);

  logic                 valid_q;
  logic [8:0]           heading_q;
  logic                 restart_q;
  logic [7:0]           prev_err_q;
  hrpd_pkg::hrpd_dir_e  prev_dir_q;

  logic [8:0]           tgt_fold, meas_fold;
  logic signed [9:0]    err;
  logic signed [9:0]    mag_wide;
  hrpd_pkg::hrpd_dir_e  dir;
  logic [7:0]           mag, last, diff;
  logic                 advance;

  assign ready_o = !valid_q || ready_i;
  assign advance = valid_q && ready_i;
  assign valid_o = valid_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      heading_q <= measured_heading_i;
      restart_q <= restart_i;
    end
  end

  // fold headings above 359 once, then signed error
  always_comb begin
    tgt_fold  = (cfg_i.target_heading >= hrpd_pkg::FullCircle) ?
                cfg_i.target_heading - hrpd_pkg::FullCircle : cfg_i.target_heading;
    meas_fold = (heading_q >= hrpd_pkg::FullCircle) ?
                heading_q - hrpd_pkg::FullCircle : heading_q;
    err       = $signed({1'b0, tgt_fold}) - $signed({1'b0, meas_fold});
  end

  // wrap to at most 180 degrees and pick direction
  always_comb begin
    if (err > 10'sd0) begin
      if (err < 10'sd180) begin
        dir      = hrpd_pkg::DIR_RIGHT;
        mag_wide = err;
      end else begin
        dir      = hrpd_pkg::DIR_LEFT;
        mag_wide = 10'sd360 - err;
      end
    end else begin
      if (err > -10'sd180) begin
        dir      = hrpd_pkg::DIR_LEFT;
        mag_wide = -err;
      end else begin
        dir      = hrpd_pkg::DIR_RIGHT;
        mag_wide = 10'sd360 + err;
      end
    end
    mag = mag_wide[7:0];
  end

  // derivative history is dropped on restart or direction change
  always_comb begin
    if (restart_q || prev_dir_q == hrpd_pkg::DIR_NONE || dir != prev_dir_q) begin
      last = 8'd0;
    end else begin
      last = prev_err_q;
    end
    diff = (mag > last) ? mag - last : last - mag;
  end

  always_comb begin
    err_o.mag        = mag;
    err_o.diff       = diff;
    err_o.turn_right = (dir == hrpd_pkg::DIR_RIGHT);
    err_o.bang       = (cfg_i.commanded_speed < cfg_i.slow_speed_limit) &&
                       ({1'b0, mag} > {1'b0, cfg_i.error_deadband});
  end

  // history updates as the item leaves this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= 8'd0;
      prev_dir_q <= hrpd_pkg::DIR_NONE;
    end else if (advance) begin
      prev_err_q <= mag;
      prev_dir_q <= dir;
    end
  end

endmodule

// ----- rtl/hrpd_drive_stage.sv -----
module hrpd_drive_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hrpd_pkg::hrpd_err_t err_i,
  input  hrpd_pkg::hrpd_cfg_t cfg_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hrpd_pkg::hrpd_drv_t drv_o
);

  logic                valid_q;
  hrpd_pkg::hrpd_err_t err_q;
  logic [10:0]         diff10;
  logic [23:0]         p_term;
  logic [26:0]         d_term;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      err_q <= err_i;
    end
  end

  // drive = kp * mag + kd * 10 * diff, Q19.8 degrees
  always_comb begin
    diff10 = {err_q.diff, 3'b000} + {2'b00, err_q.diff, 1'b0};
    p_term = cfg_i.prop_gain * err_q.mag;
    d_term = cfg_i.deriv_gain * diff10;
    drv_o.drive      = {3'b000, p_term} + d_term;
    drv_o.mag        = err_q.mag;
    drv_o.turn_right = err_q.turn_right;
    drv_o.bang       = err_q.bang;
  end

endmodule

// ----- rtl/hrpd_output_stage.sv -----
module hrpd_output_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hrpd_pkg::hrpd_drv_t drv_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [10:0]         rudder_pulse_us_o,
  output logic                turn_right_o,
  output logic [7:0]          error_magnitude_o,
  output logic [6:0]          rudder_percent_o
);

  logic                s2_valid_q, out_valid_q;
  logic                s2_en, out_en;
  hrpd_pkg::hrpd_drv_t drv_q;
  logic [31:0]         prod;
  logic [6:0]          pct;
  logic [8:0]          pct5;
  logic [10:0]         pulse;
  logic [10:0]         pulse_q;
  logic                right_q;
  logic [7:0]          mag_q;
  logic [6:0]          pct_q;

  assign out_en  = !out_valid_q || ready_i;
  assign s2_en   = !s2_valid_q || out_en;
  assign ready_o = s2_en;
  assign valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= valid_i;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && valid_i) begin
      drv_q <= drv_i;
    end
  end

  // floored percent with saturation and bang-bang override
  always_comb begin
    prod = {18'd0, drv_q.drive[13:0]} * {14'd0, hrpd_pkg::PctRecip};
    if (drv_q.bang || drv_q.drive >= hrpd_pkg::DriveSatLimit) begin
      pct = hrpd_pkg::PercentMax;
    end else begin
      pct = prod[hrpd_pkg::PctShift +: 7];
    end
  end

  // 5 us per percent around center, plus for left
  always_comb begin
    pct5 = {pct, 2'b00} + {2'b00, pct};
    if (drv_q.turn_right) begin
      pulse = hrpd_pkg::PulseCenter - {2'b00, pct5};
    end else begin
      pulse = hrpd_pkg::PulseCenter + {2'b00, pct5};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      pulse_q <= pulse;
      right_q <= drv_q.turn_right;
      mag_q   <= drv_q.mag;
      pct_q   <= pct;
    end
  end

  assign rudder_pulse_us_o = pulse_q;
  assign turn_right_o      = right_q;
  assign error_magnitude_o = mag_q;
  assign rudder_percent_o  = pct_q;

endmodule

// ----- rtl/heading_rudder_pd_controller.sv -----
// Heading rudder PD controller with low-speed bang-bang override.
// hdg_i carries one request per control tick: a compass heading and a
// restart flag that drops the derivative history. res_o returns exactly
// one result per request, in order: servo pulse (1000..2000 us), turn
// direction, wrapped error magnitude and rudder percent.
// Both channels use valid/ready; a transfer happens when both are high.
// Gains, target heading and speed thresholds sit in APB registers at
// byte address 4*i; the user writes them only while no request is in
// flight (not enforced by the block). An accepted request passes the
// drive, percent and result registers. Throughput: one request per
// cycle unless res_o stalls; the turn history register updates as each
// request leaves the input register, so the next one sees it at once.
// The pipeline stages each hold one request; when the receiver stalls,
// empty stages keep filling, and hdg_i.ready drops only once all are full.
// Reset clears all valid flags and the turn history, and loads the
// register reset values (gain 7.0, speed limit 17, deadband 10).
module heading_rudder_pd_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hrpd_in_if.sink                    hdg_i,
  hrpd_out_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hrpd_pkg::AddrW-1:0] paddr,
  input  logic [hrpd_pkg::DataW-1:0] pwdata,
  output logic [hrpd_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  hrpd_pkg::hrpd_cfg_t cfg;
  hrpd_pkg::hrpd_err_t err;
  hrpd_pkg::hrpd_drv_t drv;
  logic                err_valid, err_ready;
  logic                drv_valid, drv_ready;

  // configuration registers
  hrpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // heading error and direction
  hrpd_error_stage u_err (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (hdg_i.valid),
    .ready_o            (hdg_i.ready),
    .measured_heading_i (hdg_i.measured_heading),
    .restart_i          (hdg_i.restart),
    .cfg_i              (cfg),
    .valid_o            (err_valid),
    .ready_i            (err_ready),
    .err_o              (err)
  );

  // gain products
  hrpd_drive_stage u_drv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .err_i   (err),
    .cfg_i   (cfg),
    .valid_o (drv_valid),
    .ready_i (drv_ready),
    .drv_o   (drv)
  );

  // percent, pulse and result register
  hrpd_output_stage u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (drv_valid),
    .ready_o           (drv_ready),
    .drv_i             (drv),
    .valid_o           (res_o.valid),
    .ready_i           (res_o.ready),
    .rudder_pulse_us_o (res_o.rudder_pulse_us),
    .turn_right_o      (res_o.turn_right),
    .error_magnitude_o (res_o.error_magnitude),
    .rudder_percent_o  (res_o.rudder_percent)
  );

endmodule

// ----- rtl/hrpd_checker.sv -----
module hrpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [10:0] rudder_pulse_us_i,
  input logic        turn_right_i,
  input logic [7:0]  error_magnitude_i,
  input logic [6:0]  rudder_percent_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(rudder_pulse_us_i) &&
    $stable(turn_right_i) && $stable(error_magnitude_i) && $stable(rudder_percent_i))
    else $error("result changed while stalled");

  // pulse matches percent and direction
  a_pulse_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !turn_right_i |->
    rudder_pulse_us_i == 11'd1500 + {4'd0, rudder_percent_i} * 11'd5)
    else $error("left pulse does not match percent");

  a_pulse_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && turn_right_i |->
    rudder_pulse_us_i == 11'd1500 - {4'd0, rudder_percent_i} * 11'd5)
    else $error("right pulse does not match percent");

  // ranges after wrap and saturation
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> rudder_percent_i <= 7'd100 && error_magnitude_i <= 8'd180)
    else $error("percent or error out of range");

  // zero error steers left, the derivative term may still deflect
  a_zero_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && error_magnitude_i == 8'd0 |-> !turn_right_i)
    else $error("zero error steered right");

endmodule

bind heading_rudder_pd_controller hrpd_checker u_hrpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .rudder_pulse_us_i (res_o.rudder_pulse_us),
  .turn_right_i      (res_o.turn_right),
  .error_magnitude_i (res_o.error_magnitude),
  .rudder_percent_i  (res_o.rudder_percent)
);

// ----- tb/sv/heading_rudder_pd_checker.sv -----
`timescale 1ns / 100ps

module heading_rudder_pd_checker
  import hrpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hrpd_in_if               hdg_i,
  hrpd_out_if              res_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int unsigned      pending_o,
  output int unsigned      fail_cnt_o
);

  typedef struct packed {
    logic [10:0] pulse;
    logic        turn_right;
    logic [7:0]  mag;
    logic [6:0]  pct;
  } rudder_t;

  localparam longint unsigned FullScaleQ8  = 45 * 256;
  localparam int unsigned     UsPerPercent = 5;
  localparam int unsigned     PulseMaxUs   = 2000;
  localparam int unsigned     PulseMinUs   = 1000;

  hrpd_cfg_t   cfg_q;
  logic [7:0]  prior_mag_q;
  hrpd_dir_e   prior_dir_q;
  rudder_t     rudder_exp_q[$];
  int unsigned fails;

  // compass values of 360 and up wrap once
  function automatic int fold_deg(input logic [8:0] v);
    int h;
    h = v;
    if (h >= 360) h -= 360;
    return h;
  endfunction

  // expected rudder command for one heading request
  function automatic rudder_t predict_rudder(input logic [8:0] hdg, input logic new_track);
    int              err;
    int unsigned     mag, prior, diff, percent, pulse;
    hrpd_dir_e       dir;
    longint unsigned drive, pct_raw;
    rudder_t         r;
    err = fold_deg(cfg_q.target_heading) - fold_deg(hdg);
    // shortest way round, exact half turn goes by sign
    if (err > 0) begin
      dir = (err < 180) ? DIR_RIGHT : DIR_LEFT;
      mag = (err < 180) ? err : 360 - err;
    end else begin
      dir = (err > -180) ? DIR_LEFT : DIR_RIGHT;
      mag = (err > -180) ? -err : 360 + err;
    end
    // derivative history only holds on a continued turn the same way
    prior = (new_track || prior_dir_q == DIR_NONE || prior_dir_q != dir) ? 0 : prior_mag_q;
    diff  = (mag > prior) ? mag - prior : prior - mag;
    drive = cfg_q.prop_gain * 64'(mag) + cfg_q.deriv_gain * 64'(diff) * 10;
    pct_raw = drive * 100 / FullScaleQ8;
    percent = (pct_raw > PercentMax) ? PercentMax : pct_raw;
    // bang-bang at low speed
    if (cfg_q.commanded_speed < cfg_q.slow_speed_limit && mag > cfg_q.error_deadband)
      percent = PercentMax;
    pulse = (dir == DIR_LEFT) ? PulseCenter + UsPerPercent * percent
                              : PulseCenter - UsPerPercent * percent;
    if (pulse > PulseMaxUs) pulse = PulseMaxUs;
    if (pulse < PulseMinUs) pulse = PulseMinUs;
    r.pulse      = 11'(pulse);
    r.turn_right = (dir == DIR_RIGHT);
    r.mag        = 8'(mag);
    r.pct        = 7'(percent);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rudder_t got, want;
    if (!rst_ni) begin
      cfg_q.target_heading   = TargetHeadingRst;
      cfg_q.commanded_speed  = CommandedSpeedRst;
      cfg_q.prop_gain        = PropGainRst;
      cfg_q.deriv_gain       = DerivGainRst;
      cfg_q.slow_speed_limit = SlowSpeedRst;
      cfg_q.error_deadband   = DeadbandRst;
      prior_mag_q = '0;
      prior_dir_q = DIR_NONE;
      rudder_exp_q.delete();
      fails = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      // register writes seen on the bus
      if (psel && penable && pwrite && pready) begin
        case (hrpd_reg_e'(paddr[4:2]))
          REG_TARGET_HEADING:   cfg_q.target_heading   = pwdata[8:0];
          REG_COMMANDED_SPEED:  cfg_q.commanded_speed  = pwdata[7:0];
          REG_PROP_GAIN:        cfg_q.prop_gain        = pwdata[15:0];
          REG_DERIV_GAIN:       cfg_q.deriv_gain       = pwdata[15:0];
          REG_SLOW_SPEED_LIMIT: cfg_q.slow_speed_limit = pwdata[7:0];
          REG_ERROR_DEADBAND:   cfg_q.error_deadband   = pwdata[7:0];
          default: ;
        endcase
      end
      // compare each result with the oldest expectation
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.rudder_pulse_us, res_i.turn_right, res_i.error_magnitude,
                res_i.rudder_percent};
        if (rudder_exp_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result pulse=%0d right=%0d mag=%0d pct=%0d",
                     $realtime, got.pulse, got.turn_right, got.mag, got.pct);
          fails++;
        end else begin
          want = rudder_exp_q.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch exp pulse=%0d right=%0d mag=%0d pct=%0d,",
                       $realtime, want.pulse, want.turn_right, want.mag, want.pct,
                       " got pulse=%0d right=%0d mag=%0d pct=%0d",
                       got.pulse, got.turn_right, got.mag, got.pct);
            fails++;
          end
        end
      end
      // predict each accepted request and advance the turn history
      if (hdg_i.valid && hdg_i.ready) begin
        want = predict_rudder(hdg_i.measured_heading, hdg_i.restart);
        rudder_exp_q.push_back(want);
        prior_mag_q = want.mag;
        prior_dir_q = want.turn_right ? DIR_RIGHT : DIR_LEFT;
      end
      pending_o  <= rudder_exp_q.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

// ----- tb/sv/heading_rudder_pd_controller_tb.sv -----
`timescale 1ns / 100ps

module heading_rudder_pd_controller_tb;
  import hrpd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 48;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned RandPhases = 11;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  int unsigned      pending, fail_cnt, stall_cnt;
  bit               idle_en = 1'b1;
  bit               hold_req = 1'b0;
  int               tgt_deg = 0;

  hrpd_in_if  hdg_if ();
  hrpd_out_if res_if ();

  heading_rudder_pd_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hdg_i   (hdg_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  heading_rudder_pd_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hdg_i      (hdg_if),
    .res_i      (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  always #4 clk_i = ~clk_i;

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((hdg_if.valid && hdg_if.ready) || (res_if.valid && res_if.ready) || psel || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  // drop valid and wait until every result is back
  task automatic drain_results();
    hdg_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input hrpd_reg_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned tgt, input int unsigned spd,
                           input int unsigned kp, input int unsigned kd,
                           input int unsigned lim, input int unsigned db);
    drain_results();
    apb_write(REG_TARGET_HEADING, tgt);
    apb_write(REG_COMMANDED_SPEED, spd);
    apb_write(REG_PROP_GAIN, kp);
    apb_write(REG_DERIV_GAIN, kd);
    apb_write(REG_SLOW_SPEED_LIMIT, lim);
    apb_write(REG_ERROR_DEADBAND, db);
    tgt_deg = (tgt >= 360) ? tgt - 360 : tgt;
  endtask

  // leaves valid high so the next request can follow without a gap
  task automatic send_heading(input logic [8:0] hdg, input logic new_track);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      hdg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hdg_if.valid            <= 1'b1;
    hdg_if.measured_heading <= hdg;
    hdg_if.restart          <= new_track;
    @(posedge clk_i);
    while (!hdg_if.ready) @(posedge clk_i);
  endtask

  // mostly modest gains so the percent does not always saturate
  function automatic int unsigned draw_gain(input int unsigned typ_max);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, typ_max);
  endfunction

  task automatic run_phase(input int ph);
    int          hdg;
    int unsigned pick;
    logic [8:0]  meas;
    logic        trk;
    case (ph)
      0: write_cfg(511, 255, 65535, 65535, 255, 255);
      1: write_cfg(0, 0, 0, 0, 0, 0);
      2: write_cfg(TargetHeadingRst, CommandedSpeedRst, PropGainRst, DerivGainRst,
                   SlowSpeedRst, DeadbandRst);
      default: write_cfg($urandom_range(0, 511), $urandom_range(0, 255), draw_gain(2048),
                         draw_gain(512), $urandom_range(0, 255),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(181, 255)
                                                     : $urandom_range(0, 180));
    endcase
    hdg = 0;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
      // back-to-back requests against a stalled receiver
      if (ph == 3 && i == 20) begin
        idle_en  = 1'b0;
        hold_req = 1'b1;
      end
      if (ph == 6 && i == 75) drain_results();
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 5) begin
        // new track, often starting near the target
        hdg  = (pick % 2) ? $urandom_range(0, 359)
                          : (tgt_deg + $urandom_range(0, 60) + 330) % 360;
        meas = 9'(hdg);
        trk  = 1'b1;
      end else if (pick < 85) begin
        // slow drift of the measured heading
        hdg  = (hdg + $urandom_range(0, 20) + 350) % 360;
        meas = 9'(hdg);
        trk  = 1'b0;
      end else begin
        meas = 9'($urandom_range(0, 511));
        trk  = 1'($urandom_range(0, 1));
      end
      send_heading(meas, trk);
    end
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    hdg_if.valid            <= 1'b0;
    hdg_if.measured_heading <= '0;
    hdg_if.restart          <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero error, wrap at north, deadband edge, half turn, folded headings
    send_heading(0, 1);
    send_heading(359, 0);
    send_heading(1, 0);
    send_heading(10, 0);
    send_heading(11, 0);
    send_heading(180, 0);
    send_heading(360, 0);
    send_heading(511, 1);
    send_heading(200, 0);

    // all registers at their maximum, folded target
    write_cfg(511, 255, 65535, 65535, 255, 255);
    send_heading(331, 1);
    send_heading(151, 0);
    send_heading(150, 0);
    send_heading(145, 0);

    // unit gains, deadband out of reach, derivative and restart
    write_cfg(180, 0, 256, 256, 1, 200);
    send_heading(0, 1);
    send_heading(90, 0);
    send_heading(100, 0);
    send_heading(100, 1);
    send_heading(270, 0);

    // everything zero
    write_cfg(0, 0, 0, 0, 0, 0);
    send_heading(5, 0);
    send_heading(300, 0);

    for (int ph = 0; ph < RandPhases; ph++) run_phase(ph);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hrpd_pkg.sv
rtl/hrpd_if.sv
rtl/hrpd_cfg_regs.sv
rtl/hrpd_error_stage.sv
rtl/hrpd_drive_stage.sv
rtl/hrpd_output_stage.sv
rtl/heading_rudder_pd_controller.sv
rtl/hrpd_checker.sv
tb/sv/heading_rudder_pd_checker.sv
tb/sv/heading_rudder_pd_controller_tb.sv
